### src/ugpi_pkg.sv
// Shared types, codes and default sizes of the uniform grid point index.
`default_nettype none
package ugpi_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int GRID_X_DEF   = 8;
    localparam int GRID_Z_DEF   = 8;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_PT   = 2'd0,
        KIND_DONE = 2'd1,
        KIND_ACK  = 2'd2,
        KIND_CELL = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        REG_BOX_MIN_X = 3'd0,
        REG_BOX_MAX_X = 3'd1,
        REG_BOX_MIN_Y = 3'd2,
        REG_BOX_MAX_Y = 3'd3,
        REG_BOX_MIN_Z = 3'd4,
        REG_BOX_MAX_Z = 3'd5,
        REG_SCALE_X   = 3'd6,
        REG_SCALE_Z   = 3'd7
    } t_reg;

    typedef struct packed {
        t_cmd               cmd;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic [15:0]        entity_id;
        logic [15:0]        radius;
        logic [5:0]         max_count;
        logic               exclude_self;
        logic [7:0]         cell_sel;
        logic               last;
    } t_in_item;

    typedef struct packed {
        t_kind              kind;
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic signed [15:0] out_z;
        logic [15:0]        out_entity;
        logic [5:0]         count;
        logic [5:0]         offset;
        logic               final_res;
    } t_out_item;

    typedef struct packed {
        logic  cap;
        logic  stg_wr;
        logic  cm_init;
        logic  sort_step;
        logic  cell_end;
        logic  commit_fin;
        logic  clr;
        logic  q_mul;
        logic  q_step;
        logic  out_load;
        t_kind out_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
        logic staged_zero;
        logic elem_last;
        logic cell_last;
        logic q_end;
        logic q_match;
        logic o_free;
    } t_dp_sts;

endpackage
`default_nettype wire

### src/ugpi_if.sv
// Valid/ready channel interfaces for items, results and register writes.
`default_nettype none
interface ugpi_in_if;
    import ugpi_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ugpi_out_if;
    import ugpi_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ugpi_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### src/ugpi_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module ugpi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### src/ugpi_ctrl.sv
// Controller state machine: load, batch sort, clear, cell read and radius query sequencing.
`default_nettype none
module ugpi_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire ugpi_pkg::t_cmd    i_in_cmd,
    output logic                   o_in_ready,
    input  wire ugpi_pkg::t_dp_sts i_sts,
    output ugpi_pkg::t_dp_cmd      o_cmd
);
    import ugpi_pkg::*;

    typedef enum logic [15:0] {
        S_IDLE   = 16'h0001,
        S_LCALC  = 16'h0002,
        S_LWR    = 16'h0004,
        S_CSTART = 16'h0008,
        S_CRD    = 16'h0010,
        S_CCHK   = 16'h0020,
        S_CEND   = 16'h0040,
        S_CFIN   = 16'h0080,
        S_ACK    = 16'h0100,
        S_CLR    = 16'h0200,
        S_RCELL  = 16'h0400,
        S_COUT   = 16'h0800,
        S_QCHK   = 16'h1000,
        S_QMUL   = 16'h2000,
        S_QCMP   = 16'h4000,
        S_QDONE  = 16'h8000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = i_rst_n && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    case (i_in_cmd)
                        CMD_LOAD:  n_state = S_LCALC;
                        CMD_QUERY: n_state = S_QCHK;
                        CMD_CLEAR: n_state = S_CLR;
                        default:   n_state = S_RCELL;
                    endcase
                end
            end
            S_LCALC: n_state = S_LWR;
            S_LWR: begin
                o_cmd.stg_wr = 1'b1;
                n_state = i_sts.last ? S_CSTART : S_IDLE;
            end
            S_CSTART: begin
                if (i_sts.staged_zero) begin
                    n_state = S_ACK;
                end else begin
                    o_cmd.cm_init = 1'b1;
                    n_state = S_CRD;
                end
            end
            S_CRD: n_state = S_CCHK;
            S_CCHK: begin
                o_cmd.sort_step = 1'b1;
                n_state = i_sts.elem_last ? S_CEND : S_CRD;
            end
            S_CEND: begin
                o_cmd.cell_end = 1'b1;
                n_state = i_sts.cell_last ? S_CFIN : S_CRD;
            end
            S_CFIN: begin
                o_cmd.commit_fin = 1'b1;
                n_state = S_ACK;
            end
            S_ACK: begin
                if (i_sts.o_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = KIND_ACK;
                    n_state = S_IDLE;
                end
            end
            S_CLR: begin
                o_cmd.clr = 1'b1;
                n_state = S_IDLE;
            end
            S_RCELL: n_state = S_COUT;
            S_COUT: begin
                if (i_sts.o_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = KIND_CELL;
                    n_state = S_IDLE;
                end
            end
            S_QCHK: n_state = i_sts.q_end ? S_QDONE : S_QMUL;
            S_QMUL: begin
                o_cmd.q_mul = 1'b1;
                n_state = S_QCMP;
            end
            S_QCMP: begin
                if (!i_sts.q_match || i_sts.o_free) begin
                    o_cmd.q_step   = 1'b1;
                    o_cmd.out_load = i_sts.q_match;
                    o_cmd.out_sel  = KIND_PT;
                    n_state = S_QCHK;
                end
            end
            S_QDONE: begin
                if (i_sts.o_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = KIND_DONE;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

### src/ugpi_dp.sv
// Datapath: box registers, cell mapping, staging and point stores, cell table, query compare.
`default_nettype none
module ugpi_dp #(
    parameter int CAPACITY = ugpi_pkg::CAPACITY_DEF,
    parameter int GRID_X   = ugpi_pkg::GRID_X_DEF,
    parameter int GRID_Z   = ugpi_pkg::GRID_Z_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire ugpi_pkg::t_in_item  i_in_data,
    input  wire ugpi_pkg::t_dp_cmd   i_cmd,
    output ugpi_pkg::t_dp_sts        o_sts,
    input  wire logic                i_cfg_we,
    input  wire logic [2:0]          i_cfg_index,
    input  wire logic [15:0]         i_cfg_data,
    input  wire logic                i_out_ready,
    output logic                     o_out_valid,
    output ugpi_pkg::t_out_item      o_out_data
);
    import ugpi_pkg::*;

    localparam int NCELLS = GRID_X * GRID_Z;
    localparam int AW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNTW   = $clog2(CAPACITY + 1);
    localparam int CELLW  = (NCELLS > 1) ? $clog2(NCELLS) : 1;
    localparam int GXW    = (GRID_X > 1) ? $clog2(GRID_X) : 1;
    localparam int GZW    = (GRID_Z > 1) ? $clog2(GRID_Z) : 1;
    localparam logic signed [35:0] OFF_X = 36'((GRID_X / 2) * 8192);
    localparam logic signed [35:0] OFF_Z = 36'((GRID_Z / 2) * 8192);
    localparam logic [4:0] GMAX_X = 5'(GRID_X - 1);
    localparam logic [4:0] GMAX_Z = 5'(GRID_Z - 1);

    // floor(t / 8192) clamped to 0 .. gmax
    function automatic logic [4:0] f_axis(input logic signed [34:0] prod,
                                          input logic signed [35:0] off,
                                          input logic [4:0] gmax);
        logic signed [35:0] t;
        logic [22:0]        q;
        t = $signed({prod[34], prod}) + off;
        q = t[35:13];
        if (t < 0) begin
            f_axis = '0;
        end else if (q > 23'(gmax)) begin
            f_axis = gmax;
        end else begin
            f_axis = q[4:0];
        end
    endfunction

    logic signed [15:0] r_min_x, r_max_x, r_min_y, r_max_y, r_min_z, r_max_z;
    logic [15:0]        r_scale_x, r_scale_z;
    t_in_item           r_q;
    logic [CNTW-1:0]    r_staged, r_stored, r_i, r_n, r_start;
    logic [CELLW-1:0]   r_c;
    logic signed [34:0] r_prod_x, r_prod_z;
    logic               r_inside;
    logic [NCELLS-1:0]  r_cvalid;
    logic [31:0]        r_dx2, r_dy2, r_dz2, r_r2;
    logic [63:0]        r_pt;
    logic               r_ovalid;
    t_out_item          r_odata, n_odata;

    logic [63:0]         stg_pt_rdata, ps_rdata;
    logic [CELLW-1:0]    stg_cell_rdata;
    logic [2*CNTW-1:0]   ct_rdata;
    logic signed [17:0]  rel_x, rel_z;
    logic                inside_c;
    logic [4:0]          ax_x, ax_z;
    logic [8:0]          cell_num;
    logic                stg_we, sort_match, ps_we, ct_we;
    logic [CNTW-1:0]     pos;
    logic signed [16:0]  dx, dy, dz;
    logic signed [33:0]  sqx, sqy, sqz;
    logic [33:0]         d2;
    logic                sel_ok;
    logic [CELLW-1:0]    sel_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x   <= 16'sh8000;
            r_max_x   <= 16'sh7FFF;
            r_min_y   <= 16'sh8000;
            r_max_y   <= 16'sh7FFF;
            r_min_z   <= 16'sh8000;
            r_max_z   <= 16'sh7FFF;
            r_scale_x <= '0;
            r_scale_z <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_BOX_MIN_X: r_min_x   <= i_cfg_data;
                REG_BOX_MAX_X: r_max_x   <= i_cfg_data;
                REG_BOX_MIN_Y: r_min_y   <= i_cfg_data;
                REG_BOX_MAX_Y: r_max_y   <= i_cfg_data;
                REG_BOX_MIN_Z: r_min_z   <= i_cfg_data;
                REG_BOX_MAX_Z: r_max_z   <= i_cfg_data;
                REG_SCALE_X:   r_scale_x <= i_cfg_data;
                default:       r_scale_z <= i_cfg_data;
            endcase
        end
    end

    // cell mapping, doubled relative position times scale
    assign rel_x = ($signed({{2{r_q.pos_x[15]}}, r_q.pos_x}) <<< 1)
                 - ($signed({{2{r_min_x[15]}}, r_min_x}) + $signed({{2{r_max_x[15]}}, r_max_x}));
    assign rel_z = ($signed({{2{r_q.pos_z[15]}}, r_q.pos_z}) <<< 1)
                 - ($signed({{2{r_min_z[15]}}, r_min_z}) + $signed({{2{r_max_z[15]}}, r_max_z}));
    assign inside_c = (r_q.pos_x >= r_min_x) && (r_q.pos_x <= r_max_x)
                   && (r_q.pos_y >= r_min_y) && (r_q.pos_y <= r_max_y)
                   && (r_q.pos_z >= r_min_z) && (r_q.pos_z <= r_max_z);

    always_ff @(posedge i_clk) begin
        r_prod_x <= rel_x * $signed({1'b0, r_scale_x});
        r_prod_z <= rel_z * $signed({1'b0, r_scale_z});
        r_inside <= inside_c;
    end

    assign ax_x     = f_axis(r_prod_x, OFF_X, GMAX_X);
    assign ax_z     = f_axis(r_prod_z, OFF_Z, GMAX_Z);
    assign cell_num = 9'(ax_z[GZW-1:0]) * 9'(GRID_X) + 9'(ax_x[GXW-1:0]);

    assign stg_we     = i_cmd.stg_wr && r_inside && (r_staged < CNTW'(CAPACITY));
    assign sort_match = (stg_cell_rdata == r_c);
    assign ps_we      = i_cmd.sort_step && sort_match;
    assign pos        = r_start + r_n;
    assign ct_we      = i_cmd.cell_end && (r_n != '0);

    ugpi_ram #(.WIDTH(64), .DEPTH(CAPACITY)) u_stg_pt (
        .i_clk   (i_clk),
        .i_we    (stg_we),
        .i_waddr (r_staged[AW-1:0]),
        .i_wdata ({r_q.pos_x, r_q.pos_y, r_q.pos_z, r_q.entity_id}),
        .i_raddr (r_i[AW-1:0]),
        .o_rdata (stg_pt_rdata)
    );

    ugpi_ram #(.WIDTH(CELLW), .DEPTH(CAPACITY)) u_stg_cell (
        .i_clk   (i_clk),
        .i_we    (stg_we),
        .i_waddr (r_staged[AW-1:0]),
        .i_wdata (cell_num[CELLW-1:0]),
        .i_raddr (r_i[AW-1:0]),
        .o_rdata (stg_cell_rdata)
    );

    ugpi_ram #(.WIDTH(64), .DEPTH(CAPACITY)) u_store (
        .i_clk   (i_clk),
        .i_we    (ps_we),
        .i_waddr (pos[AW-1:0]),
        .i_wdata (stg_pt_rdata),
        .i_raddr (r_i[AW-1:0]),
        .o_rdata (ps_rdata)
    );

    assign sel_idx = r_q.cell_sel[CELLW-1:0];
    assign sel_ok  = (9'(r_q.cell_sel) < 9'(NCELLS));

    ugpi_ram #(.WIDTH(2 * CNTW), .DEPTH(NCELLS)) u_cells (
        .i_clk   (i_clk),
        .i_we    (ct_we),
        .i_waddr (r_c),
        .i_wdata ({r_n, r_start}),
        .i_raddr (sel_idx),
        .o_rdata (ct_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_staged <= '0;
            r_stored <= '0;
            r_cvalid <= '0;
        end else begin
            if (stg_we) begin
                r_staged <= r_staged + 1'b1;
            end
            if (i_cmd.commit_fin) begin
                r_stored <= r_staged;
                r_staged <= '0;
            end
            if (i_cmd.clr) begin
                r_cvalid <= '0;
            end else if (ct_we) begin
                r_cvalid[r_c] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_q <= i_in_data;
            r_i <= '0;
            r_n <= '0;
        end
        if (i_cmd.cm_init) begin
            r_i     <= '0;
            r_n     <= '0;
            r_start <= '0;
            r_c     <= '0;
        end
        if (i_cmd.sort_step) begin
            r_i <= r_i + 1'b1;
            if (sort_match) begin
                r_n <= r_n + 1'b1;
            end
        end
        if (i_cmd.cell_end) begin
            r_start <= pos;
            r_n     <= '0;
            r_i     <= '0;
            r_c     <= r_c + 1'b1;
        end
        if (i_cmd.q_step) begin
            r_i <= r_i + 1'b1;
            if (o_sts.q_match) begin
                r_n <= r_n + 1'b1;
            end
        end
    end

    // query distance, squares registered before the sum
    assign dx  = $signed({ps_rdata[63], ps_rdata[63:48]}) - $signed({r_q.pos_x[15], r_q.pos_x});
    assign dy  = $signed({ps_rdata[47], ps_rdata[47:32]}) - $signed({r_q.pos_y[15], r_q.pos_y});
    assign dz  = $signed({ps_rdata[31], ps_rdata[31:16]}) - $signed({r_q.pos_z[15], r_q.pos_z});
    assign sqx = dx * dx;
    assign sqy = dy * dy;
    assign sqz = dz * dz;

    always_ff @(posedge i_clk) begin
        if (i_cmd.q_mul) begin
            r_dx2 <= sqx[31:0];
            r_dy2 <= sqy[31:0];
            r_dz2 <= sqz[31:0];
            r_r2  <= r_q.radius * r_q.radius;
            r_pt  <= ps_rdata;
        end
    end

    assign d2 = 34'(r_dx2) + 34'(r_dy2) + 34'(r_dz2);

    assign o_sts.last        = r_q.last;
    assign o_sts.staged_zero = (r_staged == '0);
    assign o_sts.elem_last   = (r_i == r_staged - 1'b1);
    assign o_sts.cell_last   = (r_c == CELLW'(NCELLS - 1));
    assign o_sts.q_end       = (r_i == r_stored)
                            || ((r_q.max_count != '0) && (6'(r_n) == r_q.max_count));
    assign o_sts.q_match     = !(r_q.exclude_self && (r_pt[15:0] == r_q.entity_id))
                            && (d2 <= 34'(r_r2));
    assign o_sts.o_free      = !r_ovalid || i_out_ready;

    always_comb begin
        n_odata      = '0;
        n_odata.kind = i_cmd.out_sel;
        case (i_cmd.out_sel)
            KIND_PT: begin
                n_odata.out_x      = r_pt[63:48];
                n_odata.out_y      = r_pt[47:32];
                n_odata.out_z      = r_pt[31:16];
                n_odata.out_entity = r_pt[15:0];
                n_odata.count      = 6'(r_n + 1'b1);
            end
            KIND_DONE: begin
                n_odata.count     = 6'(r_n);
                n_odata.final_res = 1'b1;
            end
            KIND_ACK: begin
                n_odata.count     = 6'(r_stored);
                n_odata.final_res = 1'b1;
            end
            default: begin
                if (sel_ok && r_cvalid[sel_idx]) begin
                    n_odata.count  = 6'(ct_rdata[2*CNTW-1:CNTW]);
                    n_odata.offset = 6'(ct_rdata[CNTW-1:0]);
                end
                n_odata.final_res = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_odata <= n_odata;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;
endmodule
`default_nettype wire

### src/uniform_grid_point_index_top.sv
// Uniform grid point index: x/z grid binning, counting sort and radius query.
//
// Channels: i_in takes command transactions (load point, radius query, clear
// cells, read cell), o_out returns result transactions, i_cfg writes the box
// and scale registers (ready whenever out of reset, write only while idle).
// One command is worked on at a time; i_in is ready only when the sequencer
// is idle, and may take the next command while a result still sits in the
// output register.
// Steps per command: a load captures the point, registers the scaled products and
// writes the staging RAMs; a load with last then sorts the batch by a cell by cell
// scan of the staging RAMs. A query scans the stored points with read, square and
// compare steps for each scanned point.
// Results come from one output register; when o_out is stalled the sequencer
// holds at the next result until the register empties, so nothing is lost.
// Reset (i_rst_n low, synchronous) empties staging and store counts, marks
// every cell entry as zero and loads the register defaults. No clearing pass.
`default_nettype none
module uniform_grid_point_index_top #(
    parameter int CAPACITY = ugpi_pkg::CAPACITY_DEF,
    parameter int GRID_X   = ugpi_pkg::GRID_X_DEF,
    parameter int GRID_Z   = ugpi_pkg::GRID_Z_DEF
) (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    ugpi_in_if.sink   i_in,
    ugpi_out_if.source o_out,
    ugpi_cfg_if.sink  i_cfg
);
    import ugpi_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    logic    in_ready;

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = i_rst_n;

    ugpi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_cmd   (i_in.data.cmd),
        .o_in_ready (in_ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    ugpi_dp #(
        .CAPACITY (CAPACITY),
        .GRID_X   (GRID_X),
        .GRID_Z   (GRID_Z)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in.data),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_data  (o_out.data)
    );
endmodule
`default_nettype wire

### sim/uniform_grid_point_index_top_test.sv
// Self-checking testbench of the uniform grid point index: load, sort, cell read and radius query.
`timescale 1ns / 100ps
`default_nettype none
module uniform_grid_point_index_top_test;
    import ugpi_pkg::*;

    localparam int CAP   = CAPACITY_DEF;
    localparam int GX    = GRID_X_DEF;
    localparam int GZ    = GRID_Z_DEF;
    localparam int CELLS = GX * GZ;

    typedef struct {
        logic signed [15:0] x, y, z;
        logic [15:0]        ent;
    } t_point;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ugpi_in_if  in_ch ();
    ugpi_out_if out_ch ();
    ugpi_cfg_if cfg_ch ();

    uniform_grid_point_index_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    logic [15:0] regs [8];
    t_point      staged_pts [CAP];
    logic [7:0]  staged_cell [CAP];
    int          n_staged;
    t_point      stored_pts [CAP];
    int          n_stored;
    logic [5:0]  cnt_tab [CELLS];
    logic [5:0]  off_tab [CELLS];

    t_out_item expected_results [$];
    int        n_errors = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        hold_off = 0;

    function automatic int cell_of_axis(logic signed [15:0] p, logic signed [15:0] lo,
                                        logic signed [15:0] hi, logic [15:0] scale, int grid);
        longint rel2, t, c;
        rel2 = 2 * longint'(p) - (longint'(lo) + longint'(hi));
        t = rel2 * longint'({1'b0, scale}) + longint'(grid / 2) * 8192;
        if (t < 0) return 0;
        c = t / 8192;
        if (c > grid - 1) c = grid - 1;
        return int'(c);
    endfunction

    function automatic t_out_item blank_result(t_kind k, int cnt, int off, logic fin);
        t_out_item r;
        r = '0;
        r.kind = k;
        r.count = cnt[5:0];
        r.offset = off[5:0];
        r.final_res = fin;
        return r;
    endfunction

    function automatic void expect_result(t_out_item r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic void sort_into_store();
        int pos, n, start;
        pos = 0;
        if (n_staged == 0) return;
        for (int c = 0; c < CELLS; c++) begin
            n = 0;
            start = pos;
            for (int i = 0; i < n_staged; i++) begin
                if (staged_cell[i] == c) begin
                    stored_pts[pos] = staged_pts[i];
                    pos++;
                    n++;
                end
            end
            if (n != 0) begin
                cnt_tab[c] = n[5:0];
                off_tab[c] = start[5:0];
            end
        end
        n_stored = n_staged;
        n_staged = 0;
    endfunction

    function automatic void predict_index(t_in_item it);
        logic signed [15:0] mnx, mxx, mny, mxy, mnz, mxz;
        t_point p;
        t_out_item r;
        longint dx, dy, dz, d2, r2;
        int n, cx, cz;
        mnx = regs[REG_BOX_MIN_X]; mxx = regs[REG_BOX_MAX_X];
        mny = regs[REG_BOX_MIN_Y]; mxy = regs[REG_BOX_MAX_Y];
        mnz = regs[REG_BOX_MIN_Z]; mxz = regs[REG_BOX_MAX_Z];
        p.x = it.pos_x; p.y = it.pos_y; p.z = it.pos_z; p.ent = it.entity_id;
        case (it.cmd)
            CMD_LOAD: begin
                if (p.x >= mnx && p.x <= mxx && p.y >= mny && p.y <= mxy &&
                    p.z >= mnz && p.z <= mxz && n_staged < CAP) begin
                    cx = cell_of_axis(p.x, mnx, mxx, regs[REG_SCALE_X], GX);
                    cz = cell_of_axis(p.z, mnz, mxz, regs[REG_SCALE_Z], GZ);
                    staged_pts[n_staged] = p;
                    staged_cell[n_staged] = 8'(cz * GX + cx);
                    n_staged++;
                end
                if (it.last) begin
                    sort_into_store();
                    expect_result(blank_result(KIND_ACK, n_stored, 0, 1'b1));
                end
            end
            CMD_CLEAR: begin
                for (int c = 0; c < CELLS; c++) begin
                    cnt_tab[c] = '0;
                    off_tab[c] = '0;
                end
            end
            CMD_READ: begin
                if (it.cell_sel < CELLS)
                    expect_result(blank_result(KIND_CELL, cnt_tab[it.cell_sel],
                                               off_tab[it.cell_sel], 1'b1));
                else
                    expect_result(blank_result(KIND_CELL, 0, 0, 1'b1));
            end
            default: begin
                r2 = longint'(it.radius) * longint'(it.radius);
                n = 0;
                for (int i = 0; i < n_stored; i++) begin
                    dx = longint'(stored_pts[i].x) - longint'(p.x);
                    dy = longint'(stored_pts[i].y) - longint'(p.y);
                    dz = longint'(stored_pts[i].z) - longint'(p.z);
                    d2 = dx * dx + dy * dy + dz * dz;
                    if (!(it.exclude_self && stored_pts[i].ent == p.ent) && d2 <= r2) begin
                        n++;
                        r = blank_result(KIND_PT, n, 0, 1'b0);
                        r.out_x = stored_pts[i].x;
                        r.out_y = stored_pts[i].y;
                        r.out_z = stored_pts[i].z;
                        r.out_entity = stored_pts[i].ent;
                        expect_result(r);
                    end
                    if (it.max_count != 0 && n == it.max_count) break;
                end
                expect_result(blank_result(KIND_DONE, n, 0, 1'b1));
            end
        endcase
    endfunction

    // result ready, with random stalls and a counted hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected result transaction %p", out_ch.data);
            end else begin
                want = expected_results.pop_front();
                if (out_ch.data !== want) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch: expected %p, actual %p", want, out_ch.data);
                end
            end
        end
    end

    // valid is left high on return; the next send reloads or drops it, a drain drops it
    task automatic send_item(t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_index(it);
    endtask

    task automatic write_reg(t_reg idx, logic [15:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        regs[idx] = val;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic set_box(logic [15:0] mnx, logic [15:0] mxx, logic [15:0] mny,
                           logic [15:0] mxy, logic [15:0] mnz, logic [15:0] mxz,
                           logic [15:0] scx, logic [15:0] scz);
        drain();
        write_reg(REG_BOX_MIN_X, mnx); write_reg(REG_BOX_MAX_X, mxx);
        write_reg(REG_BOX_MIN_Y, mny); write_reg(REG_BOX_MAX_Y, mxy);
        write_reg(REG_BOX_MIN_Z, mnz); write_reg(REG_BOX_MAX_Z, mxz);
        write_reg(REG_SCALE_X, scx); write_reg(REG_SCALE_Z, scz);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic t_in_item rand_item(t_cmd c, int span);
        t_in_item it;
        it = '0;
        it.cmd = c;
        it.pos_x = 16'($urandom_range(2 * span) - span);
        it.pos_y = 16'($urandom_range(2 * span) - span);
        it.pos_z = 16'($urandom_range(2 * span) - span);
        it.entity_id = 16'($urandom_range(7));
        if ($urandom_range(9) == 0) it.entity_id = 16'($urandom);
        it.radius = 16'($urandom_range(span));
        if ($urandom_range(9) == 0) it.radius = 16'($urandom);
        it.max_count = 6'($urandom_range(3) == 0 ? $urandom : 0);
        it.exclude_self = 1'($urandom);
        it.cell_sel = 8'($urandom_range(3) == 0 ? $urandom : $urandom_range(CELLS - 1));
        it.last = 1'b0;
        return it;
    endfunction

    task automatic load_batch(int n, int span);
        t_in_item it;
        for (int i = 0; i < n; i++) begin
            it = rand_item(CMD_LOAD, span);
            if ($urandom_range(15) == 0)
                it = t_in_item'(98'({$urandom, $urandom, $urandom, $urandom}));
            it.cmd = CMD_LOAD;
            it.last = (i == n - 1);
            send_item(it);
        end
    endtask

    task automatic test_directed();
        t_in_item it;
        it = '0;
        it.cmd = CMD_LOAD; it.last = 1'b1;
        send_item(it);                                       // single-point batch ack
        it.cmd = CMD_READ; it.cell_sel = 8'hff;
        send_item(it);                                       // cell out of range
        it.cmd = CMD_QUERY; it.radius = 16'hffff;
        send_item(it);                                       // query over the one stored point
        set_box(16'hc000, 16'h4000, 16'h8000, 16'h7fff, 16'hf000, 16'h3000, 16'h0010, 16'hffff);
        it = '0; it.cmd = CMD_LOAD;
        it.pos_x = 16'sh7fff; send_item(it);                 // outside box
        it.pos_x = 16'shc000; it.pos_y = 16'sh8000; it.pos_z = 16'shf000; it.entity_id = 16'hffff;
        send_item(it);
        it.pos_x = 16'sh4000; it.pos_y = 16'sh7fff; it.pos_z = 16'sh3000; it.entity_id = 16'h0001;
        send_item(it);
        it.pos_x = 16'sh0000; it.pos_z = 16'sh0000; it.last = 1'b1;
        send_item(it);
        it = '0; it.cmd = CMD_LOAD; it.last = 1'b1; it.pos_z = 16'sh7fff;
        send_item(it);                                       // empty batch keeps old size
        for (int c = 0; c < CELLS; c += 9) begin
            it = '0; it.cmd = CMD_READ; it.cell_sel = 8'(c);
            send_item(it);
        end
        it = '0; it.cmd = CMD_QUERY; it.radius = 16'hffff; it.pos_x = 16'sh8000;
        it.pos_y = 16'sh8000; it.pos_z = 16'sh8000;
        send_item(it);
        it.exclude_self = 1'b1; it.entity_id = 16'hffff; it.max_count = 6'd1;
        send_item(it);
        it = '0; it.cmd = CMD_CLEAR; send_item(it);
        it.cmd = CMD_READ; it.cell_sel = 8'd0; send_item(it);
        set_box(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h0000, 16'h0000);
        load_batch(CAP + 4, 32000);                          // staging overflow
    endtask

    task automatic test_random(int rounds, int span);
        t_in_item it;
        for (int r = 0; r < rounds; r++) begin
            if ($urandom_range(3) != 0) load_batch($urandom_range(1, 12), span);
            for (int k = $urandom_range(1, 4); k > 0; k--) begin
                case ($urandom_range(9))
                    0: it = rand_item(CMD_CLEAR, span);
                    1, 2: it = rand_item(CMD_READ, span);
                    default: it = rand_item(CMD_QUERY, span);
                endcase
                send_item(it);
            end
        end
    endtask

    task automatic test_pressure();
        drain();
        load_batch(20, 50);
        hold_off = 600;
        test_random(4, 50);
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        for (int i = 0; i < 6; i += 2) begin
            regs[i] = 16'h8000;
            regs[i + 1] = 16'h7fff;
        end
        regs[6] = '0; regs[7] = '0;
        n_staged = 0; n_stored = 0;
        for (int c = 0; c < CELLS; c++) begin
            cnt_tab[c] = '0;
            off_tab[c] = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        send_idle_pct = 0; recv_stall_pct = 0;
        test_random(14, 60);
        set_box(16'hff00, 16'h0100, 16'hff00, 16'h0100, 16'hff00, 16'h0100, 16'h1000, 16'h2000);
        send_idle_pct = 58; recv_stall_pct = 0;
        test_random(14, 300);
        send_idle_pct = 0; recv_stall_pct = 58;
        test_random(14, 300);
        set_box(16'h0000, 16'h0000, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'hffff, 16'h0001);
        send_idle_pct = 34; recv_stall_pct = 34;
        test_random(10, 200);
        set_box(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h0100, 16'h0080);
        test_random(14, 32768);
        send_idle_pct = 0; recv_stall_pct = 0;
        test_pressure();
        drain();

        if (n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire

### uniform_grid_point_index_top.f
src/ugpi_pkg.sv
src/ugpi_if.sv
src/ugpi_ram.sv
src/ugpi_ctrl.sv
src/ugpi_dp.sv
src/uniform_grid_point_index_top.sv
sim/uniform_grid_point_index_top_test.sv
